// ===== rtl/core/lsra_pkg.sv =====
`default_nettype none

package lsra_pkg;

    // Size of the active list and width of the instruction indexes compared.
    localparam int MAX_ACTIVE = 64;
    localparam int INDEX_BITS = 16;

    // Fixed widths of the channel fields.
    localparam int FIELD_W   = 16;
    localparam int REG_OUT_W = 6;

    // Derived widths.
    localparam int KEY_W = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam int REG_W = $clog2(MAX_ACTIVE);
    localparam int CNT_W = $clog2(MAX_ACTIVE + 1);

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [REG_W-1:0] t_reg;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt FULL_CNT = t_cnt'(MAX_ACTIVE);

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROT,
        ST_POP,
        ST_ALLOC
    } t_state;

    // What every cell of the active chain does in a cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_DROP,
        OP_LOAD
    } t_cell_op;

    // Command broadcast to the chain: on a drop only cells below lim move.
    typedef struct packed {
        t_cell_op op;
        t_cnt     lim;
        t_key     load_end;
        t_reg     load_reg;
    } t_cell_cmd;

    // Control of the free register stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic rd;
    } t_fs_ctrl;

    // Low bits of a register number as carried on the result channel.
    function automatic logic [REG_OUT_W-1:0] out_reg(input t_reg r);
        logic [REG_W+REG_OUT_W-1:0] w;
        w = {{REG_OUT_W{1'b0}}, r};
        return w[REG_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lsra_if.sv =====
`default_nettype none

// Interval channel.
interface lsra_in_if;
    import lsra_pkg::*;

    logic               valid;
    logic               ready;
    logic               first_of_program;
    logic [FIELD_W-1:0] interval_start;
    logic [FIELD_W-1:0] interval_end;

    modport source (
        output valid, first_of_program, interval_start, interval_end,
        input  ready
    );
    modport sink (
        input  valid, first_of_program, interval_start, interval_end,
        output ready
    );
endinterface

// Allocation result channel.
interface lsra_out_if;
    import lsra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_OUT_W-1:0] register_index;
    logic                 overflow;

    modport source (
        output valid, register_index, overflow,
        input  ready
    );
    modport sink (
        input  valid, register_index, overflow,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/linear_scan_register_allocator.sv =====
// Linear-scan register allocator without spilling.
// i_in carries live intervals (first_of_program, interval_start, interval_end) in
// nondecreasing start order; o_out returns one register_index and an overflow flag
// per interval, in order. Both channels transfer on valid and ready high.
// One interval is in work at a time: i_in.ready is high only while the block is idle.
// The active list sits in a ring of MAX_ACTIVE cells, newest entry in cell 0. For each
// interval the ring is stepped once per active entry to expire old entries (each
// expired register is pushed onto the free stack), then rotated back into place,
// then the free stack top is read and, unless the list is full, the new entry is
// loaded into cell 0. After the scan the ring is rotated MAX_ACTIVE - 1 - kept times,
// where kept counts the entries that stay (no rotation when no entry or all entries
// are kept). The next interval can transfer in the cycle after the result is loaded.
// The result waits in an output register; if the receiver stalls, a finished result
// holds there and the next result waits until it is taken.
// Synchronous active-low reset empties the active list and the free stack and drops
// any result not yet taken. first_of_program empties the list and stack before its interval.
`default_nettype none

module linear_scan_register_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lsra_in_if.sink    i_in,
    lsra_out_if.source o_out
);
    import lsra_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_key      r_start;
    t_key      r_end;
    t_cnt      r_left;
    t_cnt      r_kept;
    t_cnt      r_rot;
    t_cnt      r_cnt;
    logic      r_out_valid;
    logic [REG_OUT_W-1:0] r_out_reg;
    logic      r_out_ovf;

    t_key      cell_end [MAX_ACTIVE];
    t_reg      cell_reg [MAX_ACTIVE];
    t_cell_cmd cell_cmd;
    t_fs_ctrl  fs_ctrl;
    t_cnt      fs_count;
    t_reg      fs_top;

    logic      in_xfer;
    logic      out_free;
    logic      head_expired;
    logic      list_full;
    t_reg      alloc_reg;
    t_cnt      rot_need;

    assign in_xfer      = i_in.valid && i_in.ready;
    assign out_free     = !r_out_valid || o_out.ready;
    assign head_expired = (cell_end[0] <= r_start);
    assign list_full    = (r_kept == FULL_CNT);
    assign alloc_reg    = (fs_count != '0) ? fs_top : r_kept[REG_W-1:0];

    // Rotations that bring the kept block back to cell 1.
    always_comb begin
        if ((r_kept == '0) || list_full) begin
            rot_need = '0;
        end else begin
            rot_need = FULL_CNT - t_cnt'(1) - r_kept;
        end
    end

    // Chain of cells; each takes from its upper neighbor, the last from cell 0.
    for (genvar k = 0; k < MAX_ACTIVE; k++) begin : g_cell
        localparam int NB = (k + 1) % MAX_ACTIVE;
        lsra_cell u_cell (
            .i_clk     (i_clk),
            .i_idx     (t_reg'(k)),
            .i_cmd     (cell_cmd),
            .i_nbr_end (cell_end[NB]),
            .i_nbr_reg (cell_reg[NB]),
            .o_end     (cell_end[k]),
            .o_reg     (cell_reg[k])
        );
    end

    lsra_fstack u_fstack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (fs_ctrl),
        .i_push_data (cell_reg[0]),
        .o_count     (fs_count),
        .o_top       (fs_top)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_xfer) n_state = ST_SCAN;
            ST_SCAN:  if (r_left == '0) n_state = ST_ROT;
            ST_ROT:   if (r_rot == '0) n_state = ST_POP;
            ST_POP:   n_state = ST_ALLOC;
            ST_ALLOC: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: chain command, stack control, input ready.
    always_comb begin
        i_in.ready        = 1'b0;
        cell_cmd.op       = OP_HOLD;
        cell_cmd.lim      = r_left - t_cnt'(1);
        cell_cmd.load_end = r_end;
        cell_cmd.load_reg = alloc_reg;
        fs_ctrl           = '0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready    = 1'b1;
                fs_ctrl.clear = in_xfer && i_in.first_of_program;
            end
            ST_SCAN: begin
                if (r_left != '0) begin
                    if (head_expired) begin
                        cell_cmd.op  = OP_DROP;
                        fs_ctrl.push = 1'b1;
                    end else begin
                        cell_cmd.op = OP_ROTATE;
                    end
                end
            end
            ST_ROT: begin
                if (r_rot != '0) begin
                    cell_cmd.op = OP_ROTATE;
                end
            end
            ST_POP: begin
                fs_ctrl.rd = 1'b1;
            end
            ST_ALLOC: begin
                if (out_free && !list_full) begin
                    cell_cmd.op = OP_LOAD;
                    fs_ctrl.pop = (fs_count != '0);
                end
            end
            default: begin
                cell_cmd.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Captured interval.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_start <= i_in.interval_start[KEY_W-1:0];
            r_end   <= i_in.interval_end[KEY_W-1:0];
        end
    end

    // Scan, rotation and occupancy counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_kept <= '0;
            r_rot  <= '0;
            r_cnt  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_left <= i_in.first_of_program ? '0 : r_cnt;
                        r_kept <= '0;
                    end
                end
                ST_SCAN: begin
                    if (r_left != '0) begin
                        r_left <= r_left - t_cnt'(1);
                        if (!head_expired) begin
                            r_kept <= r_kept + t_cnt'(1);
                        end
                    end else begin
                        r_rot <= rot_need;
                    end
                end
                ST_ROT: begin
                    if (r_rot != '0) begin
                        r_rot <= r_rot - t_cnt'(1);
                    end
                end
                ST_ALLOC: begin
                    if (out_free) begin
                        r_cnt <= list_full ? r_kept : (r_kept + t_cnt'(1));
                    end
                end
                default: begin
                    r_rot <= r_rot;
                end
            endcase
        end
    end

    // Output register; a new result loads when the old one is gone or taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_ALLOC) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_ALLOC) && out_free) begin
            r_out_reg <= list_full ? '0 : out_reg(alloc_reg);
            r_out_ovf <= list_full;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.register_index = r_out_reg;
    assign o_out.overflow       = r_out_ovf;

endmodule

`default_nettype wire

// ===== rtl/core/lsra_cell.sv =====
`default_nettype none

// One entry of the active chain: holds an interval end and its register.
module lsra_cell (
    input  wire logic              i_clk,
    input  wire lsra_pkg::t_reg    i_idx,
    input  wire lsra_pkg::t_cell_cmd i_cmd,
    input  wire lsra_pkg::t_key    i_nbr_end,
    input  wire lsra_pkg::t_reg    i_nbr_reg,
    output lsra_pkg::t_key         o_end,
    output lsra_pkg::t_reg         o_reg
);
    import lsra_pkg::*;

    t_key r_end;
    t_reg r_reg;
    t_key n_end;
    t_reg n_reg;

    // Pick the next contents: take from the upper neighbor, load, or hold.
    always_comb begin
        n_end = r_end;
        n_reg = r_reg;
        case (i_cmd.op)
            OP_ROTATE: begin
                n_end = i_nbr_end;
                n_reg = i_nbr_reg;
            end
            OP_DROP: begin
                if (t_cnt'(i_idx) < i_cmd.lim) begin
                    n_end = i_nbr_end;
                    n_reg = i_nbr_reg;
                end
            end
            OP_LOAD: begin
                if (i_idx == '0) begin
                    n_end = i_cmd.load_end;
                    n_reg = i_cmd.load_reg;
                end
            end
            default: begin
                n_end = r_end;
                n_reg = r_reg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_end <= n_end;
        r_reg <= n_reg;
    end

    assign o_end = r_end;
    assign o_reg = r_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lsra_fstack.sv =====
`default_nettype none

// Last-in-first-out stack of released registers, held in a memory.
module lsra_fstack (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsra_pkg::t_fs_ctrl i_ctrl,
    input  wire lsra_pkg::t_reg    i_push_data,
    output lsra_pkg::t_cnt         o_count,
    output lsra_pkg::t_reg         o_top
);
    import lsra_pkg::*;

    t_reg r_mem [MAX_ACTIVE];
    t_cnt r_count;
    t_reg r_top;
    t_cnt rd_ptr;
    logic can_push;

    assign can_push = (r_count < FULL_CNT);
    assign rd_ptr   = r_count - t_cnt'(1);

    // Fill level; a push onto a full stack is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
        end else if (i_ctrl.push && can_push) begin
            r_count <= r_count + t_cnt'(1);
        end else if (i_ctrl.pop && (r_count != '0)) begin
            r_count <= r_count - t_cnt'(1);
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && can_push) begin
            r_mem[r_count[REG_W-1:0]] <= i_push_data;
        end
    end

    // Registered read of the top entry.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_top <= r_mem[rd_ptr[REG_W-1:0]];
        end
    end

    assign o_count = r_count;
    assign o_top   = r_top;

endmodule

`default_nettype wire

// ===== rtl/core/lsra_chk.sv =====
`default_nettype none

// Port-level checks of the allocator.
module lsra_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [lsra_pkg::REG_OUT_W-1:0] i_out_reg,
    input wire logic                           i_out_ovf
);
    import lsra_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // Only one interval is in work: ready drops right after a transfer.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("input ready stayed high after an input transfer");

    // No result appears right after a transfer.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after an input transfer");

    // An overflow result carries register zero.
    a_ovf_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ovf) |-> (i_out_reg == '0))
        else $error("overflow result with nonzero register");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_reg) && $stable(i_out_ovf)))
        else $error("stalled result changed");

endmodule

bind linear_scan_register_allocator lsra_chk u_lsra_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_reg   (o_out.register_index),
    .i_out_ovf   (o_out.overflow)
);

`default_nettype wire

// ===== bench/linear_scan_register_allocator_test.sv =====
`timescale 1ns / 100ps

module linear_scan_register_allocator_test;
    import lsra_pkg::*;

    // One allocation result as the block should return it.
    typedef struct {
        logic [REG_OUT_W-1:0] register_index;
        logic                 overflow;
    } t_grant;

    // Tracks the active list and free stack and queues the grants they imply.
    class register_allocation_tracker;
        t_key        live_end[MAX_ACTIVE];
        int unsigned live_reg[MAX_ACTIVE];
        int unsigned live_count;
        int unsigned free_regs[MAX_ACTIVE];
        int unsigned free_count;
        t_grant      expected_grants[$];
        int          error_count;

        function new();
            live_count  = 0;
            free_count  = 0;
            error_count = 0;
        endfunction

        // Work out the grant for an interval that the block has taken.
        function void note_interval(logic first, logic [FIELD_W-1:0] start_in,
                                    logic [FIELD_W-1:0] end_in);
            t_key        start_key;
            t_key        end_key;
            int unsigned phys;
            int          idx;
            int          j;
            t_grant      grant;
            start_key = t_key'(start_in);
            end_key   = t_key'(end_in);
            if (first) begin
                live_count = 0;
                free_count = 0;
            end
            // Walk the active list from the back and release every expired entry.
            idx = live_count;
            while (idx > 0) begin
                idx = idx - 1;
                if (live_end[idx] <= start_key) begin
                    if (free_count < MAX_ACTIVE) begin
                        free_regs[free_count] = live_reg[idx];
                        free_count++;
                    end
                    for (j = idx; j + 1 < live_count; j++) begin
                        live_end[j] = live_end[j + 1];
                        live_reg[j] = live_reg[j + 1];
                    end
                    live_count--;
                end
            end
            if (live_count >= MAX_ACTIVE) begin
                grant.register_index = '0;
                grant.overflow       = 1'b1;
            end else begin
                if (free_count > 0) begin
                    free_count--;
                    phys = free_regs[free_count];
                end else begin
                    phys = live_count;
                end
                live_end[live_count] = end_key;
                live_reg[live_count] = phys;
                live_count++;
                grant.register_index = REG_OUT_W'(phys);
                grant.overflow       = 1'b0;
            end
            expected_grants.push_back(grant);
        endfunction

        // Compare a transferred result with the oldest expected grant.
        function void check_grant(logic [REG_OUT_W-1:0] register_index, logic overflow);
            t_grant want;
            if (expected_grants.size() == 0) begin
                $error("unexpected result: register_index %0d, overflow %0d",
                       register_index, overflow);
                error_count++;
                return;
            end
            want = expected_grants.pop_front();
            if (register_index !== want.register_index) begin
                $error("register_index: expected %0d, actual %0d",
                       want.register_index, register_index);
                error_count++;
            end
            if (overflow !== want.overflow) begin
                $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   items_sent;

    register_allocation_tracker tracker;

    lsra_in_if  intervals_if ();
    lsra_out_if grants_if ();

    linear_scan_register_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (intervals_if),
        .o_out   (grants_if)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Known values on every input from time zero.
    initial begin
        i_rst_n                       <= 1'b0;
        intervals_if.valid            <= 1'b0;
        intervals_if.first_of_program <= 1'b0;
        intervals_if.interval_start   <= '0;
        intervals_if.interval_end     <= '0;
        grants_if.ready               <= 1'b0;
    end

    // Offer one interval, at random after a gap, and wait for its transfer.
    task automatic send_interval(input logic first, input logic [FIELD_W-1:0] start_in,
                                 input logic [FIELD_W-1:0] end_in);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            intervals_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        intervals_if.valid            <= 1'b1;
        intervals_if.first_of_program <= first;
        intervals_if.interval_start   <= start_in;
        intervals_if.interval_end     <= end_in;
        do @(posedge i_clk); while (intervals_if.ready !== 1'b1);
        tracker.note_interval(first, start_in, end_in);
        items_sent++;
    endtask

    // One program of intervals, mostly in start order; mode picks how long they live.
    task automatic run_program(input int mode, input int len);
        int   pos;
        int   span;
        int   stop;
        int   k;
        logic first;
        pos = (mode == 2) ? $urandom_range(0, 2000) : $urandom_range(0, 65000);
        for (k = 0; k < len; k++) begin
            first = (k == 0);
            if (k > 0 && $urandom_range(0, 24) == 0) begin
                // Noise: arbitrary fields, now and then a fresh program.
                send_interval(1'($urandom_range(0, 1)), FIELD_W'($urandom),
                              FIELD_W'($urandom));
                continue;
            end
            pos = pos + $urandom_range(0, 3);
            if (pos > 65535) pos = 65535;
            case (mode)
                0: span = $urandom_range(0, 10);
                1: span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
                                                      : $urandom_range(0, 20);
                default: span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8)
                                                            : 65535;
            endcase
            stop = pos + span;
            if (stop > 65535) stop = 65535;
            if ($urandom_range(0, 29) == 0) begin
                // Broken order: an end before its start, or a start that steps back.
                if ($urandom_range(0, 1) == 0) stop = $urandom_range(0, pos);
                else send_interval(first, FIELD_W'($urandom_range(0, pos)), FIELD_W'(stop));
            end
            send_interval(first, FIELD_W'(pos), FIELD_W'(stop));
        end
    endtask

    // Receiver: check each transfer and stall at random.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && grants_if.valid === 1'b1 && grants_if.ready === 1'b1)
                tracker.check_grant(grants_if.register_index, grants_if.overflow);
            if (stall_left > 0) begin
                stall_left--;
                grants_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                grants_if.ready <= 1'b0;
            end else begin
                grants_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int mode;
        tracker    = new();
        idle_on    = 1'b1;
        items_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: state straight after reset, LIFO reuse, odd orders, extremes.
        send_interval(1'b0, 16'd0, 16'd0);
        send_interval(1'b0, 16'd0, 16'd5);
        send_interval(1'b0, 16'd1, 16'd3);
        send_interval(1'b0, 16'd2, 16'd4);
        send_interval(1'b0, 16'd4, 16'd10);
        send_interval(1'b0, 16'd4, 16'd10);
        send_interval(1'b0, 16'd20, 16'd7);
        send_interval(1'b0, 16'd15, 16'hFFFF);
        send_interval(1'b0, 16'd3, 16'd30);
        send_interval(1'b0, 16'd40, 16'd41);
        send_interval(1'b0, 16'hFFFF, 16'hFFFF);
        send_interval(1'b0, 16'hFFFF, 16'd0);
        send_interval(1'b1, 16'hFFFF, 16'd0);
        send_interval(1'b1, 16'hAAAA, 16'h5555);
        send_interval(1'b0, 16'h5555, 16'hAAAA);
        send_interval(1'b0, 16'hAAAA, 16'hFFFF);
        send_interval(1'b1, 16'd0, 16'hFFFF);
        send_interval(1'b0, 16'd0, 16'd0);

        // Random programs; the long-lived ones fill the active list past full.
        while (items_sent < 1600) begin
            idle_on = !((items_sent >= 600 && items_sent < 750) || items_sent >= 1400);
            mode = $urandom_range(0, 99);
            if (mode < 40)      run_program(0, $urandom_range(1, 120));
            else if (mode < 75) run_program(1, $urandom_range(1, 120));
            else                run_program(2, $urandom_range(66, 100));
        end
        intervals_if.valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (2 * MAX_ACTIVE + 20) @(posedge i_clk);
        if (tracker.error_count == 0 && tracker.pending() == 0) begin
            $display("linear_scan_register_allocator_test: clean");
        end else begin
            $display("linear_scan_register_allocator_test: errors");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("linear_scan_register_allocator_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lsra_pkg.sv
rtl/core/lsra_if.sv
rtl/core/lsra_cell.sv
rtl/core/lsra_fstack.sv
rtl/core/linear_scan_register_allocator.sv
rtl/core/lsra_chk.sv
bench/linear_scan_register_allocator_test.sv
